FILE: sv/tsnm_pkg.sv
`default_nettype none
package tsnm_pkg;

   // fixed field widths
   localparam int DIM_W     = 9;
   localparam int VEC_W     = 48;
   localparam int LANE_W    = 16;
   localparam int IDX_W     = 3;
   localparam int TADDR_W   = 16;
   localparam int COLOR_W   = 24;
   localparam int COORD_W   = 17;
   localparam int OUT_W     = 16;

   // parameter defaults
   localparam int MAX_DIM_DEF     = 256;
   localparam int STORE_DEPTH_DEF = 65536;
   localparam int FRAC_BITS_DEF   = 14;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MAP_WIDTH  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_MAP_HEIGHT = 3'd1;
   localparam logic [IDX_W-1:0] CSR_TANGENT    = 3'd2;
   localparam logic [IDX_W-1:0] CSR_BITANGENT  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_NORMAL     = 3'd4;

   // commands
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register reset values
   localparam logic [DIM_W-1:0] DIM_RESET       = 9'd256;
   localparam logic [VEC_W-1:0] TANGENT_RESET   = 48'h0000_4000_0000;
   localparam logic [VEC_W-1:0] BITANGENT_RESET = 48'h0000_0000_4000;
   localparam logic [VEC_W-1:0] NORMAL_RESET    = 48'h0000_0000_4000;

   typedef struct packed {
      logic               command;
      logic [TADDR_W-1:0] texel_address;
      logic [COLOR_W-1:0] texel_color;
      logic [COORD_W-1:0] tex_u;
      logic [COORD_W-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] world_x;
      logic signed [OUT_W-1:0] world_y;
      logic signed [OUT_W-1:0] world_z;
      logic                    degenerate;
   } rsp_type;

   // component idx of a packed x,y,z vector
   function automatic logic signed [LANE_W-1:0] lane(input logic [VEC_W-1:0] vec,
                                                     input logic [1:0] idx);
      logic signed [LANE_W-1:0] res;
      case (idx)
         2'd0:    res = vec[47:32];
         2'd1:    res = vec[31:16];
         default: res = vec[15:0];
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: sv/tsnm_ram.sv
`default_nettype none
module tsnm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     wr_en,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

FILE: sv/tangent_space_normal_map_sample.sv
`default_nettype none
// channel   handshake               payload
// req       req_valid / req_ready   req_data  (req_type: write texel or sample)
// rsp       rsp_valid / rsp_ready   rsp_data  (rsp_type: one per sample)
// csr       csr_valid / csr_ready   csr_index, csr_data (always ready)
//
// a write item goes into the texture ram at acceptance
// a sample runs through address, ram read, the serial multiply-accumulate, the
// magnitudes, the one-bit-per-cycle scaling, the sum of squares, the square root and
// the 1-bit-per-cycle divider; a zero vector goes straight to emit after the
// magnitudes; one item is at work at a time
// a finished result waits in the output register; the next item is taken meanwhile
// reset is synchronous and clears control and configuration; the ram is not cleared
module tangent_space_normal_map_sample
   import tsnm_pkg::*;
#(
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [VEC_W-1:0] csr_data
);

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int POS_W = 10;
   localparam int LIN_W = 20;
   localparam int N_W   = 9;
   localparam int W_W   = 27;
   localparam int NRM_W = 21;
   localparam int Q_W   = 44;
   localparam int X_W   = 63;
   localparam int R_W   = 32;
   localparam int NW    = 31 + FRAC_BITS;
   localparam int DC_W  = $clog2(NW);
   localparam logic [W_W-1:0] M_HIGH = W_W'(1) << NRM_W;
   localparam logic [W_W-1:0] M_LOW  = W_W'(1) << (NRM_W - 1);
   localparam logic [NW-1:0]  LIM    = NW'(1) << FRAC_BITS;
   localparam logic [NW-1:0]  POS_MAX = NW'(32767);
   localparam logic [NW-1:0]  NEG_MAX = NW'(32768);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_ADDR   = 12'b0000_0000_0010,
      ST_READ   = 12'b0000_0000_0100,
      ST_MAC    = 12'b0000_0000_1000,
      ST_MAGS   = 12'b0000_0001_0000,
      ST_NORM   = 12'b0000_0010_0000,
      ST_SQUARE = 12'b0000_0100_0000,
      ST_ROOT   = 12'b0000_1000_0000,
      ST_DLOAD  = 12'b0001_0000_0000,
      ST_DSTEP  = 12'b0010_0000_0000,
      ST_DOUT   = 12'b0100_0000_0000,
      ST_EMIT   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [VEC_W-1:0] tan_ff, tan_in, bitan_ff, bitan_in, nrm_ff, nrm_in;

   logic [POS_W-1:0]        col_ff, col_in, row_ff, row_in;
   logic                    black_ff, black_in;
   logic signed [N_W-1:0]   n_ff [3];
   logic signed [N_W-1:0]   n_in [3];
   logic [1:0]              i_ff, i_in, j_ff, j_in;
   logic signed [W_W-1:0]   w_ff [3];
   logic signed [W_W-1:0]   w_in [3];
   logic [W_W-1:0]          a_ff [3];
   logic [W_W-1:0]          a_in [3];
   logic [W_W-1:0]          m_ff, m_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic [X_W-1:0]          rem_x_ff, rem_x_in, root_ff, root_in, bit_ff, bit_in;
   logic [R_W-1:0]          r_ff, r_in;
   logic [NW-1:0]           num_ff, num_in, quot_ff, quot_in;
   logic [R_W-1:0]          drem_ff, drem_in;
   logic [DC_W-1:0]         dcnt_ff, dcnt_in;
   logic signed [OUT_W-1:0] res_ff [3];
   logic signed [OUT_W-1:0] res_in [3];
   logic                    degen_ff, degen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // ram port
   logic [AW-1:0]      ram_addr;
   logic               ram_we;
   logic [COLOR_W-1:0] ram_rdata;

   tsnm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_we),
      .wr_data (req_data.texel_color),
      .rd_data (ram_rdata)
   );

   // dimension write saturates at the largest map
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (32'(v) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   logic                      req_acc;
   logic [COORD_W+DIM_W-1:0]  u_prod, v_prod;
   logic [LIN_W-1:0]          lin_addr;
   logic                      in_map;
   logic [31:0]               lin32, wr32;
   logic [VEC_W-1:0]          basis;
   logic signed [24:0]        mac_prod;
   logic [W_W-1:0]            mag_v [3];
   logic [X_W-1:0]            root_try;
   logic [R_W:0]              trial;
   logic [NW-1:0]             kc;
   logic [COLOR_W-1:0]        texel;

   assign req_acc = req_valid && req_ready;

   always_comb begin
      // defaults hold every register
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      tan_in       = tan_ff;
      bitan_in     = bitan_ff;
      nrm_in       = nrm_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      black_in     = black_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      m_in         = m_ff;
      q_in         = q_ff;
      rem_x_in     = rem_x_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      r_in         = r_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      drem_in      = drem_ff;
      dcnt_in      = dcnt_ff;
      res_in       = res_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // texel position
      u_prod   = req_data.tex_u * (COORD_W+DIM_W)'(width_ff);
      v_prod   = req_data.tex_v * (COORD_W+DIM_W)'(height_ff);
      in_map   = (col_ff < POS_W'(width_ff)) && (row_ff < POS_W'(height_ff));
      lin_addr = LIN_W'(row_ff) * LIN_W'(width_ff) + LIN_W'(col_ff);
      lin32    = 32'(lin_addr);
      wr32     = 32'(req_data.texel_address);

      // ram address and write enable
      ram_we   = 1'b0;
      ram_addr = lin32[AW-1:0];
      if (state_ff == ST_IDLE) begin
         ram_addr = wr32[AW-1:0];
         ram_we   = req_acc && (req_data.command == CMD_WRITE) &&
                    (wr32 < 32'(STORE_DEPTH));
      end

      texel = black_ff ? '0 : ram_rdata;

      // multiply-accumulate operand
      case (j_ff)
         2'd0:    basis = tan_ff;
         2'd1:    basis = bitan_ff;
         default: basis = nrm_ff;
      endcase
      mac_prod = 25'(n_ff[j_ff]) * 25'(lane(basis, i_ff));

      for (int k = 0; k < 3; k++) begin
         mag_v[k] = w_ff[k][W_W-1] ? W_W'(-w_ff[k]) : W_W'(w_ff[k]);
      end

      root_try = root_ff + bit_ff;
      trial    = {drem_ff, num_ff[NW-1]};
      kc       = (quot_ff > LIM) ? LIM : quot_ff;

      // output register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.command == CMD_SAMPLE)) begin
               col_in   = u_prod[16 +: POS_W];
               row_in   = v_prod[16 +: POS_W];
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            black_in = !(in_map && (lin32 < 32'(STORE_DEPTH)));
            state_in = ST_READ;
         end
         ST_READ: begin
            n_in[0]  = $signed({1'b0, texel[23:16]}) * 9'sd2 - 9'sd255;
            n_in[1]  = $signed({1'b0, texel[15:8]})  * 9'sd2 - 9'sd255;
            n_in[2]  = $signed({1'b0, texel[7:0]})   * 9'sd2 - 9'sd255;
            for (int k = 0; k < 3; k++) w_in[k] = '0;
            i_in     = 2'd0;
            j_in     = 2'd0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            w_in[i_ff] = w_ff[i_ff] + W_W'(mac_prod);
            if (j_ff == 2'd2) begin
               j_in = 2'd0;
               i_in = i_ff + 2'd1;
               if (i_ff == 2'd2) state_in = ST_MAGS;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end
         ST_MAGS: begin
            a_in = mag_v;
            m_in = mag_v[0];
            if (mag_v[1] > m_in) m_in = mag_v[1];
            if (mag_v[2] > m_in) m_in = mag_v[2];
            if (m_in == '0) begin
               for (int k = 0; k < 3; k++) res_in[k] = '0;
               degen_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               degen_in = 1'b0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // one bit of scaling per cycle
            if (m_ff >= M_HIGH) begin
               m_in = m_ff >> 1;
               for (int k = 0; k < 3; k++) a_in[k] = a_ff[k] >> 1;
            end else if (m_ff < M_LOW) begin
               m_in = m_ff << 1;
               for (int k = 0; k < 3; k++) a_in[k] = a_ff[k] << 1;
            end else begin
               q_in     = '0;
               i_in     = 2'd0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            q_in = q_ff + Q_W'(a_ff[i_ff][NRM_W-1:0] * a_ff[i_ff][NRM_W-1:0]);
            i_in = i_ff + 2'd1;
            if (i_ff == 2'd2) begin
               rem_x_in = {1'b0, q_in, 18'b0};
               root_in  = '0;
               bit_in   = X_W'(1) << 62;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // digit-by-digit square root; the trial bit moves down two places per step
            if (rem_x_ff >= root_try) begin
               rem_x_in = rem_x_ff - root_try;
               root_in  = (root_ff >> 1) + bit_ff;
            end else begin
               root_in  = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               r_in     = root_in[R_W-1:0];
               i_in     = 2'd0;
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            num_in   = (NW'(a_ff[i_ff][NRM_W-1:0]) << (9 + FRAC_BITS)) +
                       NW'(r_ff >> 1);
            quot_in  = '0;
            drem_in  = '0;
            dcnt_in  = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, r_ff}) begin
               drem_in = R_W'(trial - {1'b0, r_ff});
               quot_in = {quot_ff[NW-2:0], 1'b1};
            end else begin
               drem_in = trial[R_W-1:0];
               quot_in = {quot_ff[NW-2:0], 1'b0};
            end
            num_in  = num_ff << 1;
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(NW - 1)) state_in = ST_DOUT;
         end
         ST_DOUT: begin
            // sign and saturation
            if (w_ff[i_ff][W_W-1]) begin
               res_in[i_ff] = (kc > NEG_MAX) ? -16'sd32768 : -$signed(kc[OUT_W-1:0]);
            end else begin
               res_in[i_ff] = (kc > POS_MAX) ? 16'sd32767 : $signed(kc[OUT_W-1:0]);
            end
            i_in = i_ff + 2'd1;
            state_in = (i_ff == 2'd2) ? ST_EMIT : ST_DLOAD;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.world_x    = res_ff[0];
               rsp_data_in.world_y    = res_ff[1];
               rsp_data_in.world_z    = res_ff[2];
               rsp_data_in.degenerate = degen_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // configuration writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  width_in  = clamp_dim(csr_data[DIM_W-1:0]);
            CSR_MAP_HEIGHT: height_in = clamp_dim(csr_data[DIM_W-1:0]);
            CSR_TANGENT:    tan_in    = csr_data;
            CSR_BITANGENT:  bitan_in  = csr_data;
            CSR_NORMAL:     nrm_in    = csr_data;
            default: ;
         endcase
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= clamp_dim(DIM_RESET);
         height_ff    <= clamp_dim(DIM_RESET);
         tan_ff       <= TANGENT_RESET;
         bitan_ff     <= BITANGENT_RESET;
         nrm_ff       <= NORMAL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         tan_ff       <= tan_in;
         bitan_ff     <= bitan_in;
         nrm_ff       <= nrm_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      black_ff    <= black_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      m_ff        <= m_in;
      q_ff        <= q_in;
      rem_x_ff    <= rem_x_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      r_ff        <= r_in;
      num_ff      <= num_in;
      quot_ff     <= quot_in;
      drem_ff     <= drem_in;
      dcnt_ff     <= dcnt_in;
      res_ff      <= res_in;
      degen_ff    <= degen_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a result appears only from the emit step
   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("result without emit step");

   // degenerate results carry zero vectors
   a_degen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.world_x == '0 && rsp_data.world_y == '0 && rsp_data.world_z == '0))
      else $error("degenerate result with nonzero vector");

   // divider never runs with a zero root
   a_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DSTEP) |-> (r_ff != '0))
      else $error("division by zero root");

   // no sample starts while one is in flight
   a_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> $past(state_ff == ST_IDLE))
      else $error("sample started outside idle");
`endif

endmodule
`default_nettype wire
